>>> rtl/assert_macros.svh
// Assertion macros used by the tracker unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
    `AST_HOLDS(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/rdtm_pkg.sv
// Types, constants and codes of the request id duplicate tracker.
`timescale 1ns / 1ps
`default_nettype none

package rdtm_pkg;

    // Field widths of the request and result channels
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 64;
    localparam int LEN_W    = 16;
    localparam int AUTH_W   = 64;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 3;
    localparam int USED_W   = 9;

    // Key is the length bytes plus the 16-byte authenticator
    localparam int KEY_BYTES = 18;
    localparam int KEY_BITS  = KEY_BYTES * 8;

    // Number of distinct request ids
    localparam int ID_SPACE = 1 << ID_W;

    // Parameter defaults
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_HANDLE_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_ATTACH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW        = 3'd0,
        ST_SAME       = 3'd1,
        ST_DIFF       = 3'd2,
        ST_DELETED    = 3'd3,
        ST_DEL_UNUSED = 3'd4,
        ST_ATTACHED   = 3'd5,
        ST_STALE      = 3'd6,
        ST_ALREADY    = 3'd7
    } t_status;

    // One word of the entry memory
    typedef struct packed {
        logic [TIME_W-1:0]   time_stamp;
        logic [KEY_BITS-1:0] key;
    } t_entry;

    // Actions decided for one request
    typedef struct packed {
        logic                emit;
        t_status             status;
        logic                rel_valid;
        logic [HANDLE_W-1:0] rel_handle;
        logic                wr_entry;
        t_entry              new_entry;
        logic                set_used;
        logic                clr_used;
        logic                set_present;
        logic                clr_present;
        logic                wr_reply;
    } t_act;

endpackage

`default_nettype wire

>>> rtl/rdtm_if.sv
// Request and result channel interfaces of the tracker.
`timescale 1ns / 1ps
`default_nettype none

interface rdtm_req_if;
    import rdtm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [ID_W-1:0]     entry_id;
    logic [TIME_W-1:0]   time_stamp;
    logic [LEN_W-1:0]    request_length;
    logic [AUTH_W-1:0]   auth_upper;
    logic [AUTH_W-1:0]   auth_lower;
    logic [HANDLE_W-1:0] reply_handle;

    modport source (
        output valid, operation, entry_id, time_stamp, request_length,
               auth_upper, auth_lower, reply_handle,
        input  ready
    );

    modport sink (
        input  valid, operation, entry_id, time_stamp, request_length,
               auth_upper, auth_lower, reply_handle,
        output ready
    );
endinterface

interface rdtm_rsp_if;
    import rdtm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     entry_index;
    logic                release_valid;
    logic [HANDLE_W-1:0] released_handle;
    logic [USED_W-1:0]   used_entries;

    modport source (
        output valid, status, entry_index, release_valid, released_handle,
               used_entries,
        input  ready
    );

    modport sink (
        input  valid, status, entry_index, release_valid, released_handle,
               used_entries,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/rdtm_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read.
`timescale 1ns / 1ps
`default_nettype none

module rdtm_ram #(
    parameter int WIDTH = rdtm_pkg::HANDLE_W,
    parameter int DEPTH = rdtm_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    import rdtm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one word, hold it until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> rtl/rdtm_decide.sv
// Decision logic: status, release and write-back actions for one request.
`timescale 1ns / 1ps
`default_nettype none

module rdtm_decide (
    input  wire rdtm_pkg::t_op                       i_op,
    input  wire logic [rdtm_pkg::TIME_W-1:0]         i_time_stamp,
    input  wire logic [rdtm_pkg::LEN_W-1:0]          i_request_length,
    input  wire logic [rdtm_pkg::AUTH_W-1:0]         i_auth_upper,
    input  wire logic [rdtm_pkg::AUTH_W-1:0]         i_auth_lower,
    input  wire logic [rdtm_pkg::HANDLE_W-1:0]       i_handle,
    input  wire logic                                i_used,
    input  wire logic                                i_present,
    input  wire rdtm_pkg::t_entry                    i_entry,
    input  wire logic [rdtm_pkg::HANDLE_W-1:0]       i_stored_handle,
    output rdtm_pkg::t_act                           o_act
);
    import rdtm_pkg::*;

    logic [KEY_BITS-1:0] w_key;
    logic [TIME_W-1:0]   w_ins_time;
    logic                w_key_match;
    logic                w_time_match;

    // Build the key; a zero receive time is stored as one
    assign w_key        = {i_request_length, i_auth_upper, i_auth_lower};
    assign w_ins_time   = (i_time_stamp == '0) ? TIME_W'(1) : i_time_stamp;
    assign w_key_match  = i_used && (i_entry.key == w_key);
    assign w_time_match = i_used && (i_entry.time_stamp == i_time_stamp);

    // Decide the outcome per operation
    always_comb begin
        o_act                      = '0;
        o_act.new_entry.time_stamp = w_ins_time;
        o_act.new_entry.key        = w_key;
        unique case (i_op)
            OP_INSERT: begin
                o_act.emit = 1'b1;
                if (!i_used) begin
                    o_act.status   = ST_NEW;
                    o_act.wr_entry = 1'b1;
                    o_act.set_used = 1'b1;
                end else if (w_key_match) begin
                    o_act.status = ST_SAME;
                end else begin
                    o_act.status   = ST_DIFF;
                    o_act.wr_entry = 1'b1;
                end
            end
            OP_DELETE: begin
                o_act.emit = 1'b1;
                if (!i_used) begin
                    o_act.status = ST_DEL_UNUSED;
                end else begin
                    o_act.status      = ST_DELETED;
                    o_act.clr_used    = 1'b1;
                    o_act.clr_present = 1'b1;
                    if (i_present) begin
                        o_act.rel_valid  = 1'b1;
                        o_act.rel_handle = i_stored_handle;
                    end
                end
            end
            OP_ATTACH: begin
                o_act.emit = 1'b1;
                if (!w_time_match) begin
                    o_act.status     = ST_STALE;
                    o_act.rel_valid  = 1'b1;
                    o_act.rel_handle = i_handle;
                end else if (i_present) begin
                    o_act.status     = ST_ALREADY;
                    o_act.rel_valid  = 1'b1;
                    o_act.rel_handle = i_handle;
                end else begin
                    o_act.status      = ST_ATTACHED;
                    o_act.set_present = 1'b1;
                    o_act.wr_reply    = 1'b1;
                end
            end
            default: begin
                // unknown operation: drop without a result
                o_act.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/request_id_duplicate_tracker_unit.sv
// Request id duplicate tracker: entry and reply memories with read-modify-write control.
// A request is captured and the entry and reply memories are read while idle; the result
// is registered when the evaluate state decides and writes back. No new request is taken
// until that write-back is done; a stalled result holds the write-back.
// Reset: synchronous, active low; clears the in-use flags and the count at once, and a
// reply counts only on an entry in use, so no clearing pass over the memories is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module request_id_duplicate_tracker_unit #(
    parameter int TABLE_DEPTH = rdtm_pkg::DEF_TABLE_DEPTH,
    parameter int HANDLE_BITS = rdtm_pkg::DEF_HANDLE_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rdtm_req_if.sink    i_req,
    rdtm_rsp_if.source  o_rsp
);
    import rdtm_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam logic [HANDLE_W-1:0] HANDLE_MASK =
        HANDLE_W'((17'(1) << STORE_W) - 17'(1));

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [IDX_W-1:0]    r_idx;
    logic [TIME_W-1:0]   r_time_stamp;
    logic [LEN_W-1:0]    r_request_length;
    logic [AUTH_W-1:0]   r_auth_upper;
    logic [AUTH_W-1:0]   r_auth_lower;
    logic [HANDLE_W-1:0] r_handle;

    logic                r_out_valid;
    t_status             r_out_status;
    logic [IDX_W-1:0]    r_out_idx;
    logic                r_out_rel_valid;
    logic [HANDLE_W-1:0] r_out_rel_handle;
    logic [COUNT_W-1:0]  r_out_used;

    logic [TABLE_DEPTH-1:0] r_used;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;

    logic [IDX_W-1:0]   w_mod_lut [ID_SPACE];
    logic               w_accept;
    logic               w_out_free;
    logic               w_commit;
    logic [IDX_W-1:0]   w_rd_idx;
    t_entry             w_entry_rd;
    logic [STORE_W:0]   w_reply_rd;
    logic               w_present;
    t_act               w_act;

    // Reduce the request id onto the table
    for (genvar g = 0; g < ID_SPACE; g++) begin : g_mod
        localparam logic [IDX_W-1:0] MOD_IDX = IDX_W'(g % TABLE_DEPTH);
        assign w_mod_lut[g] = MOD_IDX;
    end

    // Handshake: take a request only while idle
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_rd_idx    = w_mod_lut[i_req.entry_id];
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_commit    = (r_state == S_EVAL) && (!w_act.emit || w_out_free);

    // Entry memory: time stamp and key
    rdtm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && w_act.wr_entry),
        .i_wr_addr (r_idx),
        .i_wr_data (w_act.new_entry),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_entry_rd)
    );

    // Reply memory: present bit over the attached handle; a new entry starts with none
    rdtm_ram #(
        .WIDTH (STORE_W + 1),
        .DEPTH (TABLE_DEPTH)
    ) u_reply_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && (w_act.wr_reply || w_act.clr_present || w_act.set_used)),
        .i_wr_addr (r_idx),
        .i_wr_data ({w_act.set_present, r_handle[STORE_W-1:0]}),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_idx),
        .o_rd_data (w_reply_rd)
    );

    // A reply counts only on an entry in use
    assign w_present = r_used[r_idx] && w_reply_rd[STORE_W];

    // Decide the outcome from the read-back entry
    rdtm_decide u_decide (
        .i_op             (r_op),
        .i_time_stamp     (r_time_stamp),
        .i_request_length (r_request_length),
        .i_auth_upper     (r_auth_upper),
        .i_auth_lower     (r_auth_lower),
        .i_handle         (r_handle),
        .i_used           (r_used[r_idx]),
        .i_present        (w_present),
        .i_entry          (w_entry_rd),
        .i_stored_handle  (HANDLE_W'(w_reply_rd[STORE_W-1:0])),
        .o_act            (w_act)
    );

    // Advance the used count on commit
    always_comb begin
        n_count = r_count;
        if (w_commit && w_act.set_used) begin
            n_count = r_count + COUNT_W'(1);
        end else if (w_commit && w_act.clr_used) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    // Hold the in-use flags and the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_commit) begin
                if (w_act.set_used) begin
                    r_used[r_idx] <= 1'b1;
                end else if (w_act.clr_used) begin
                    r_used[r_idx] <= 1'b0;
                end
            end
        end
    end

    // Sequencer: capture the request, then commit and register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit && w_act.emit) begin
                r_out_valid      <= 1'b1;
                r_out_status     <= w_act.status;
                r_out_idx        <= r_idx;
                r_out_rel_valid  <= w_act.rel_valid;
                r_out_rel_handle <= w_act.rel_handle;
                r_out_used       <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op             <= t_op'(i_req.operation);
                        r_idx            <= w_rd_idx;
                        r_time_stamp     <= i_req.time_stamp;
                        r_request_length <= i_req.request_length;
                        r_auth_upper     <= i_req.auth_upper;
                        r_auth_lower     <= i_req.auth_lower;
                        r_handle         <= i_req.reply_handle & HANDLE_MASK;
                        r_state          <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Drive the result channel
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.entry_index     = ID_W'(r_out_idx);
    assign o_rsp.release_valid   = r_out_rel_valid;
    assign o_rsp.released_handle = r_out_rel_handle;
    assign o_rsp.used_entries    = USED_W'(r_out_used);

    // Count tracks the number of entries in use
    `AST_HOLDS(a_count_matches, i_clk, i_rst_n, $countones(r_used) == 32'(r_count), "used count out of step with in-use flags")
    // A waiting result keeps its payload
    `AST_HOLDS(a_result_stable, i_clk, i_rst_n, (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.status) && $stable(o_rsp.entry_index) && $stable(o_rsp.released_handle)), "waiting result changed")
    // A new result only ever follows a commit
    `AST_HOLDS(a_result_after_eval, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state) == S_EVAL, "result raised without a commit")
    // No handle is shown without a release
    `AST_HOLDS(a_handle_zero, i_clk, i_rst_n, (o_rsp.valid && !o_rsp.release_valid) |-> o_rsp.released_handle == '0, "handle shown without a release")

endmodule

`default_nettype wire

>>> verif/rdtm_tracker_checker.sv
// Checker for the request id duplicate tracker: predicts each result and compares it.
`timescale 1ns / 1ps

module rdtm_tracker_checker
    import rdtm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rdtm_req_if  i_req_mon,
    rdtm_rsp_if  i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam logic [HANDLE_W-1:0] HANDLE_KEEP =
        (DEF_HANDLE_BITS >= HANDLE_W) ? '1 : HANDLE_W'((1 << DEF_HANDLE_BITS) - 1);

    // What one request is expected to produce
    typedef struct packed {
        t_status             status;
        logic [ID_W-1:0]     index;
        logic                rel_valid;
        logic [HANDLE_W-1:0] rel_handle;
        logic [USED_W-1:0]   used;
    } t_outcome;

    // Predicted table contents
    logic [TIME_W-1:0]   slot_time   [DEPTH];
    logic [LEN_W-1:0]    slot_len    [DEPTH];
    logic [AUTH_W-1:0]   slot_upper  [DEPTH];
    logic [AUTH_W-1:0]   slot_lower  [DEPTH];
    logic                slot_has_reply [DEPTH];
    logic [HANDLE_W-1:0] slot_reply  [DEPTH];
    logic [USED_W-1:0]   live_count;

    t_outcome pending_outcomes[$];

    // Apply one request to the predicted table and return its outcome
    function automatic t_outcome track_request(
        logic [OP_W-1:0]     op,
        logic [ID_W-1:0]     id,
        logic [TIME_W-1:0]   ts,
        logic [LEN_W-1:0]    len,
        logic [AUTH_W-1:0]   upper,
        logic [AUTH_W-1:0]   lower,
        logic [HANDLE_W-1:0] handle
    );
        t_outcome res;
        int       idx;
        idx = int'(id) % DEPTH;
        handle = handle & HANDLE_KEEP;
        res = '0;
        res.index = ID_W'(idx);
        if (op == OP_INSERT) begin
            // zero time would read as unused, so hold it at one
            if (ts == '0)
                ts = TIME_W'(1);
            if (slot_time[idx] == '0) begin
                slot_time[idx]  = ts;
                slot_len[idx]   = len;
                slot_upper[idx] = upper;
                slot_lower[idx] = lower;
                live_count++;
                res.status = ST_NEW;
            end else if (slot_len[idx] == len && slot_upper[idx] == upper &&
                         slot_lower[idx] == lower) begin
                res.status = ST_SAME;
            end else begin
                // replace key and time; an attached reply stays
                slot_time[idx]  = ts;
                slot_len[idx]   = len;
                slot_upper[idx] = upper;
                slot_lower[idx] = lower;
                res.status = ST_DIFF;
            end
        end else if (op == OP_DELETE) begin
            if (slot_time[idx] == '0) begin
                res.status = ST_DEL_UNUSED;
            end else begin
                slot_time[idx] = '0;
                live_count--;
                if (slot_has_reply[idx]) begin
                    res.rel_valid  = 1'b1;
                    res.rel_handle = slot_reply[idx];
                    slot_has_reply[idx] = 1'b0;
                end
                res.status = ST_DELETED;
            end
        end else begin
            if (slot_time[idx] == '0 || slot_time[idx] != ts) begin
                res.status     = ST_STALE;
                res.rel_valid  = 1'b1;
                res.rel_handle = handle;
            end else if (slot_has_reply[idx]) begin
                res.status     = ST_ALREADY;
                res.rel_valid  = 1'b1;
                res.rel_handle = handle;
            end else begin
                slot_has_reply[idx] = 1'b1;
                slot_reply[idx]     = handle;
                res.status = ST_ATTACHED;
            end
        end
        res.used = live_count;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [ID_W-1:0] idx,
                                   longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch on %s, entry %0d: got %0h, expected %0h",
                 $realtime, what, idx, got, want);
        o_fail_count++;
    endtask

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin : watch
        t_outcome want;
        int       k;
        if (!i_rst_n) begin
            for (k = 0; k < DEPTH; k++) begin
                slot_time[k]      = '0;
                slot_has_reply[k] = 1'b0;
            end
            live_count = '0;
            pending_outcomes.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready &&
                i_req_mon.operation inside {OP_INSERT, OP_DELETE, OP_ATTACH}) begin
                pending_outcomes.push_back(track_request(
                    i_req_mon.operation, i_req_mon.entry_id, i_req_mon.time_stamp,
                    i_req_mon.request_length, i_req_mon.auth_upper,
                    i_req_mon.auth_lower, i_req_mon.reply_handle));
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                o_checked++;
                if (pending_outcomes.size() == 0) begin
                    report_mismatch("unexpected result", i_rsp_mon.entry_index,
                                    i_rsp_mon.status, 0);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (i_rsp_mon.status !== want.status)
                        report_mismatch("status", want.index, i_rsp_mon.status,
                                        want.status);
                    if (i_rsp_mon.entry_index !== want.index)
                        report_mismatch("entry_index", want.index,
                                        i_rsp_mon.entry_index, want.index);
                    if (i_rsp_mon.release_valid !== want.rel_valid)
                        report_mismatch("release_valid", want.index,
                                        i_rsp_mon.release_valid, want.rel_valid);
                    if (i_rsp_mon.released_handle !== want.rel_handle)
                        report_mismatch("released_handle", want.index,
                                        i_rsp_mon.released_handle, want.rel_handle);
                    if (i_rsp_mon.used_entries !== want.used)
                        report_mismatch("used_entries", want.index,
                                        i_rsp_mon.used_entries, want.used);
                end
            end
        end
        o_pending = pending_outcomes.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

endmodule

>>> verif/tb_request_id_duplicate_tracker_unit.sv
// Testbench top for the request id duplicate tracker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_request_id_duplicate_tracker_unit;
    import rdtm_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int PER_PHASE = 350;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   ts;
        logic [LEN_W-1:0]    len;
        logic [AUTH_W-1:0]   upper;
        logic [AUTH_W-1:0]   lower;
        logic [HANDLE_W-1:0] handle;
    } t_req_item;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   sent_count;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    // What the stimulus believes each entry holds, to build sensible sequences
    logic                seen_live  [ID_SPACE];
    logic [TIME_W-1:0]   seen_time  [ID_SPACE];
    logic [LEN_W-1:0]    seen_len   [ID_SPACE];
    logic [AUTH_W-1:0]   seen_upper [ID_SPACE];
    logic [AUTH_W-1:0]   seen_lower [ID_SPACE];

    rdtm_req_if req_ch();
    rdtm_rsp_if rsp_ch();

    request_id_duplicate_tracker_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    rdtm_tracker_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_ch),
        .i_rsp_mon    (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Give up after a generous time
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_req_item make_request(
        logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] ts,
        logic [LEN_W-1:0] len, logic [AUTH_W-1:0] upper, logic [AUTH_W-1:0] lower,
        logic [HANDLE_W-1:0] handle
    );
        t_req_item r;
        r.op = op; r.id = id; r.ts = ts; r.len = len;
        r.upper = upper; r.lower = lower; r.handle = handle;
        return r;
    endfunction

    // Build one random request, mostly well formed against the believed table
    function automatic t_req_item random_request();
        t_req_item r;
        int        pick;
        int        id;
        r = make_request(OP_INSERT, '0, rand64(), 16'($urandom), rand64(), rand64(),
                         16'($urandom));
        id = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 15) * 17
                                          : $urandom_range(0, ID_SPACE - 1);
        r.id = ID_W'(id);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r.op = OP_INSERT;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                r.ts = '0;
            else if (pick < 8)
                r.ts = '1;
            if (seen_live[id]) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    r.len   = seen_len[id];
                    r.upper = seen_upper[id];
                    r.lower = seen_lower[id];
                end
                // disturb one part of the key only
                if (pick >= 40 && pick < 45)
                    r.len[$urandom_range(0, LEN_W - 1)] ^= 1'b1;
                else if (pick >= 45 && pick < 50)
                    r.upper[$urandom_range(0, AUTH_W - 1)] ^= 1'b1;
                else if (pick >= 50 && pick < 55)
                    r.lower[$urandom_range(0, AUTH_W - 1)] ^= 1'b1;
            end
        end else if (pick < 65) begin
            r.op = OP_DELETE;
        end else if (pick < 98) begin
            r.op = OP_ATTACH;
            pick = $urandom_range(0, 99);
            if (seen_live[id] && pick < 75)
                r.ts = seen_time[id];
            else if (seen_live[id] && pick < 85)
                r.ts = seen_time[id] ^ (64'd1 << $urandom_range(0, TIME_W - 1));
            else if (pick < 90)
                r.ts = '0;
        end else begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(input t_req_item r);
        logic [TIME_W-1:0] eff_time;
        int                gap;
        int                id;
        gap = 0;
        while (gap < 24 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= r.op;
        req_ch.entry_id       <= r.id;
        req_ch.time_stamp     <= r.ts;
        req_ch.request_length <= r.len;
        req_ch.auth_upper     <= r.upper;
        req_ch.auth_lower     <= r.lower;
        req_ch.reply_handle   <= r.handle;
        // track what the table should now hold
        id = int'(r.id);
        eff_time = (r.ts == '0) ? TIME_W'(1) : r.ts;
        if (r.op == OP_INSERT) begin
            if (!(seen_live[id] && seen_len[id] == r.len && seen_upper[id] == r.upper &&
                  seen_lower[id] == r.lower)) begin
                seen_live[id]  = 1'b1;
                seen_time[id]  = eff_time;
                seen_len[id]   = r.len;
                seen_upper[id] = r.upper;
                seen_lower[id] = r.lower;
            end
        end else if (r.op == OP_DELETE) begin
            seen_live[id] = 1'b0;
        end
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int phase;
        int k;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        sent_count          = 0;
        sender_idle_pct     = 0;
        receiver_stall_pct  = 0;
        req_ch.valid          = 1'b0;
        req_ch.operation      = OP_INSERT;
        req_ch.entry_id       = '0;
        req_ch.time_stamp     = '0;
        req_ch.request_length = '0;
        req_ch.auth_upper     = '0;
        req_ch.auth_lower     = '0;
        req_ch.reply_handle   = '0;
        rsp_ch.ready          = 1'b0;
        for (k = 0; k < ID_SPACE; k++)
            seen_live[k] = 1'b0;

        // hold reset, then release it
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: extremes, every status, zero time, unknown operation
        send_request(make_request(OP_INSERT, 8'd0, '0, '0, '0, '0, '0));
        send_request(make_request(OP_INSERT, 8'd0, 64'd5, '0, '0, '0, '0));
        send_request(make_request(OP_ATTACH, 8'd0, 64'd1, '0, '0, '0, 16'h0000));
        send_request(make_request(OP_ATTACH, 8'd0, 64'd1, '0, '0, '0, 16'hFFFF));
        send_request(make_request(OP_ATTACH, 8'd0, 64'd2, '0, '0, '0, 16'h1234));
        send_request(make_request(OP_INSERT, 8'd0, 64'd3, 16'hFFFF, '0, '0, '0));
        send_request(make_request(OP_INSERT, 8'd255, '1, '1, '1, '1, '1));
        send_request(make_request(OP_ATTACH, 8'd255, '1, '1, '1, '1, 16'hFFFF));
        send_request(make_request(OP_INSERT, 8'd255, 64'd7, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE,
                                  '0));
        send_request(make_request(OP_ATTACH, 8'd255, '1, '0, '0, '0, 16'h00FF));
        send_request(make_request(OP_DELETE, 8'd255, '0, '0, '0, '0, '0));
        send_request(make_request(OP_DELETE, 8'd255, '0, '0, '0, '0, '0));
        send_request(make_request(OP_ATTACH, 8'd255, '0, '0, '0, '0, 16'hABCD));
        send_request(make_request(OP_UNUSED, 8'd0, '1, '1, '1, '1, '1));
        send_request(make_request(OP_DELETE, 8'd0, '0, '0, '0, '0, '0));
        send_request(make_request(OP_INSERT, 8'h55, {32{2'b10}}, 16'h5555, {32{2'b01}},
                                  {32{2'b10}}, '0));
        send_request(make_request(OP_INSERT, 8'hAA, {32{2'b01}}, 16'h5555, {32{2'b10}},
                                  {32{2'b10}}, '0));
        send_request(make_request(OP_INSERT, 8'hAA, 64'd9, 16'h5555, {32{2'b10}},
                                  {32{2'b01}}, '0));
        send_request(make_request(OP_ATTACH, 8'hAA, 64'd9, '0, '0, '0, 16'h5555));
        send_request(make_request(OP_DELETE, 8'h55, '0, '0, '0, '0, '0));
        send_request(make_request(OP_DELETE, 8'hAA, '0, '0, '0, '0, '0));
        hold_until_drained();

        // random: no idling, sender idle, receiver stall, both lightly
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
            endcase
            repeat (PER_PHASE) send_request(random_request());
            hold_until_drained();
        end

        // sweep: fill every entry, then empty the table again
        for (k = 0; k < ID_SPACE; k++)
            send_request(make_request(OP_INSERT, ID_W'(k), rand64(), 16'($urandom),
                                      rand64(), rand64(), '0));
        for (k = ID_SPACE - 1; k >= 0; k--)
            send_request(make_request(OP_DELETE, ID_W'(k), '0, '0, '0, '0, '0));
        hold_until_drained();
        repeat (8) @(negedge i_clk);

        $display("Run sent %0d requests (directed cases, four idling mixes, full-table sweep)",
                 sent_count);
        $display("and compared %0d results against the prediction", checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
